@@ rtl/gf2mm_pkg.sv @@
// Package for the GF(2) matrix multiply unit: word types, commands, register indexes.
// No dependencies.
`default_nettype none
package gf2mm_pkg;

  localparam int unsigned RowW = 64;
  localparam int unsigned IdxW = 6;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ROWS_A     = 3'd0,
    REG_INNER_SIZE = 3'd1,
    REG_COLS_B     = 3'd2,
    REG_CHUNK_BITS = 3'd3,
    REG_ACCUMULATE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [IdxW-1:0] row_index;
    logic [RowW-1:0] row_bits;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0] out_row_index;
    logic [RowW-1:0] out_row_bits;
    logic            last;
  } out_word_t;

  // control fields for one cell of the row
  typedef struct packed {
    logic            clear;
    logic            apply;
    logic [IdxW-1:0] row;
    logic            emit;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/gf2_matrix_multiply_unit.sv @@
// GF(2) matrix multiply unit, top level.
// Operation: load words are accepted only while idle. A compute word clears C in its
//   accept cycle (multiply mode), then stalls the input while each slice of up to k bits
//   gets a table build and an apply over the R = rows_a rows, and while R rows are emitted;
//   build reads B rows into the entries, apply reads A, then the table, and XORs into C.
// Throughput: one load word per cycle while idle, results one per cycle when not stalled.
//   Reset: synchronous active low; registers return to 64/64/64/8/0, stores undefined.
`default_nettype none
module gf2_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM   = 64,
  parameter int unsigned MAX_CHUNK = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire gf2mm_pkg::in_word_t in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output gf2mm_pkg::out_word_t  out_data,
  input  wire                   cfg_we,
  input  wire [2:0]             cfg_index,
  input  wire [6:0]             cfg_wdata
);
  import gf2mm_pkg::*;

  localparam int unsigned DimLim = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int unsigned TDepth = 1 << MAX_CHUNK;
  localparam int unsigned TW     = MAX_CHUNK;
  localparam int unsigned AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned KW     = $clog2(MAX_CHUNK + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_BUILD = 6'b000100,
    S_APPLY = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] rows_a_r, inner_r, cols_r;
  logic [3:0] chunk_r;
  logic       accum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= 7'd64; inner_r <= 7'd64; cols_r <= 7'd64;
      chunk_r <= 4'd8; accum_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:     rows_a_r <= cfg_wdata;
        REG_INNER_SIZE: inner_r  <= cfg_wdata;
        REG_COLS_B:     cols_r   <= cfg_wdata;
        REG_CHUNK_BITS: chunk_r  <= cfg_wdata[3:0];
        REG_ACCUMULATE: accum_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  function automatic logic [6:0] clamp_dim(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(DimLim)) return 7'(DimLim);
    return v;
  endfunction

  logic [6:0] nrows, ninner, ncols;
  logic [KW-1:0] kk;
  assign nrows  = clamp_dim(rows_a_r);
  assign ninner = clamp_dim(inner_r);
  assign ncols  = clamp_dim(cols_r);
  assign kk = (chunk_r == 4'd0) ? KW'(1) :
              (chunk_r > 4'(MAX_CHUNK)) ? KW'(MAX_CHUNK) : KW'(chunk_r);

  logic [RowW-1:0] col_mask;
  always_comb begin
    for (int b = 0; b < RowW; b++) col_mask[b] = (7'(b) < ncols);
  end

  // A and B stores: memories
  logic [RowW-1:0] a_mem [MAX_DIM];
  logic [RowW-1:0] b_mem [MAX_DIM];
  logic [RowW-1:0] a_rd_r, b_rd_r;
  logic [AW-1:0]   a_addr, b_addr;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  logic ld_ok;
  assign ld_ok = (32'(in_data.row_index) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (in_acc && ld_ok && in_data.cmd == CMD_LOAD_A)
      a_mem[AW'(in_data.row_index)] <= in_data.row_bits;
    if (in_acc && ld_ok && in_data.cmd == CMD_LOAD_B)
      b_mem[AW'(in_data.row_index)] <= in_data.row_bits;
    a_rd_r <= a_mem[a_addr];
    b_rd_r <= b_mem[b_addr];
  end

  // combination table: entry g (Gray-indexed) holds XOR of selected slice rows
  logic [RowW-1:0] tbl_mem [TDepth];
  logic [RowW-1:0] tbl_rd_r;
  logic [TW-1:0]   tbl_raddr;
  logic            tbl_we;
  logic [TW-1:0]   tbl_waddr;
  logic [RowW-1:0] tbl_wdata;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  // counters
  logic [6:0]    base_r, base_nxt;
  logic [KW-1:0] kcur_r, kcur_nxt;
  logic [TW:0]   i_r, i_nxt;
  logic [6:0]    j_r, j_nxt;
  logic          ph_r, ph_nxt;  // pipeline priming bit
  logic [RowW-1:0] acc_r, acc_nxt; // running table value

  // shift-chain cell row (C store)
  logic [RowW-1:0] cq [DimLim];
  logic            shift_en, clr_pulse;
  logic [6:0]      xj;
  logic            xen;
  logic [RowW-1:0] xbits;

  // low zero count of i
  logic [KW-1:0] lzc;
  always_comb begin
    lzc = '0;
    for (int t = MAX_CHUNK - 1; t >= 0; t--)
      if (i_r[t]) lzc = KW'(t);
  end

  logic [TW-1:0] gray_i;
  assign gray_i = TW'(i_r ^ (i_r >> 1));

  // output register
  out_word_t out_r;
  logic      out_v_r;
  logic      emit_go;
  assign emit_go = (state_r == S_EMIT) && (!out_v_r || !out_stall);

  always_comb begin
    state_nxt = state_r; base_nxt = base_r; kcur_nxt = kcur_r; i_nxt = i_r;
    j_nxt = j_r; ph_nxt = ph_r; acc_nxt = acc_r;
    a_addr = '0; b_addr = '0; tbl_raddr = '0;
    tbl_we = 1'b0; tbl_waddr = '0; tbl_wdata = '0;
    shift_en = 1'b0; clr_pulse = 1'b0; xen = 1'b0; xj = '0; xbits = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.cmd == CMD_COMPUTE) begin
          base_nxt = '0; j_nxt = '0;
          clr_pulse = !accum_r;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // choose next slice or finish
        if (base_r < ninner) begin
          kcur_nxt = ((ninner - base_r) >= 7'(kk)) ? kk : KW'(ninner - base_r);
          i_nxt = '0; ph_nxt = 1'b0; acc_nxt = '0;
          state_nxt = S_BUILD;
        end else begin
          j_nxt = '0; state_nxt = S_EMIT;
        end
      end
      S_BUILD: begin
        // phase 0 issues B read of base+lzc(i); phase 1 writes entry
        if (i_r == '0) begin
          tbl_we = 1'b1; tbl_waddr = '0; tbl_wdata = '0;
          i_nxt = (TW+1)'(1); ph_nxt = 1'b0;
          if (kcur_r == '0) state_nxt = S_APPLY;
        end else if (!ph_r) begin
          b_addr = AW'(base_r + 7'(lzc));
          ph_nxt = 1'b1;
        end else begin
          acc_nxt = acc_r ^ ((32'(base_r) + 32'(lzc) < MAX_DIM) ? b_rd_r : '0);
          tbl_we = 1'b1; tbl_waddr = gray_i; tbl_wdata = acc_nxt;
          ph_nxt = 1'b0;
          if (i_r == ((TW+1)'(1) << kcur_r) - 1'b1) begin
            // apply pass keys its steps off i, so it starts from zero
            i_nxt = '0; j_nxt = '0; state_nxt = S_APPLY;
          end else i_nxt = i_r + 1'b1;
        end
      end
      S_APPLY: begin
        // 3-step per row: read A, read table, xor into cell
        if (ph_r == 1'b0 && i_r[0] == 1'b0) begin
          a_addr = AW'(j_r); i_nxt = '0; i_nxt[0] = 1'b1;
        end else if (i_r[0]) begin
          tbl_raddr = TW'((a_rd_r >> base_r) & ((64'(1) << kcur_r) - 1));
          i_nxt = '0; ph_nxt = 1'b1;
        end else begin
          xen = 1'b1; xj = j_r; xbits = tbl_rd_r;
          ph_nxt = 1'b0;
          if (j_r + 7'd1 == nrows) begin
            base_nxt = base_r + 7'(kcur_r); state_nxt = S_FIN;
          end else j_nxt = j_r + 7'd1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          shift_en = 1'b1;
          if (j_r + 7'd1 == nrows) state_nxt = S_IDLE;
          else j_nxt = j_r + 7'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell row; emit shifts rows toward cell 0, wrapping so C is kept, masked to the column count
  genvar g;
  generate
    for (g = 0; g < DimLim; g++) begin : g_cell
      logic [RowW-1:0] sin;
      logic ld, clr, xe, se;
      assign ld  = in_acc && ld_ok && in_data.cmd == CMD_LOAD_C
                   && (in_data.row_index == IdxW'(g)) && state_r == S_IDLE;
      assign clr = clr_pulse && (7'(g) < nrows);
      assign xe  = xen && (xj == 7'(g));
      assign se  = shift_en && (7'(g) < nrows);
      if (g == DimLim - 1) begin : g_end
        assign sin = cq[0] & col_mask;
      end else begin : g_mid
        assign sin = (7'(g) + 7'd1 == nrows) ? (cq[0] & col_mask) : cq[g+1];
      end
      gf2mm_cell u_cell (
        .clk(clk), .ld_en(ld), .ld_bits(in_data.row_bits), .clr_en(clr),
        .xor_en(xe), .xor_bits(xbits), .shift_en(se), .shift_in(sin),
        .row_q(cq[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_v_r <= 1'b0;
      base_r <= '0; kcur_r <= '0; i_r <= '0; j_r <= '0; ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt; base_r <= base_nxt; kcur_r <= kcur_nxt;
      i_r <= i_nxt; j_r <= j_nxt; ph_r <= ph_nxt;
      if (emit_go) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
    acc_r <= acc_nxt;
    if (emit_go) begin
      out_r.out_row_index <= IdxW'(j_r);
      out_r.out_row_bits  <= cq[0] & col_mask;
      out_r.last          <= (j_r + 7'd1 == nrows);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> in_stall)
    else $error("input taken during emit");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && j_r + 7'd1 == nrows) |=> (state_r == S_IDLE))
    else $error("emit did not end on last row");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped");
endmodule
`default_nettype wire

@@ rtl/gf2mm_cell.sv @@
// One cell of the row: holds one C row word; loads, clears or shifts it, or XORs in a product contribution.
// Depends on gf2mm_pkg.
`default_nettype none
module gf2mm_cell (
  input  wire                     clk,
  input  wire                     ld_en,
  input  wire [gf2mm_pkg::RowW-1:0] ld_bits,
  input  wire                     clr_en,
  input  wire                     xor_en,
  input  wire [gf2mm_pkg::RowW-1:0] xor_bits,
  input  wire                     shift_en,
  input  wire [gf2mm_pkg::RowW-1:0] shift_in,
  output logic [gf2mm_pkg::RowW-1:0] row_q
);
  import gf2mm_pkg::*;

  logic [RowW-1:0] row_r, row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ld_en) row_nxt = ld_bits;
    else if (clr_en) row_nxt = '0;
    else if (shift_en) row_nxt = shift_in;
    else if (xor_en) row_nxt = row_r ^ xor_bits;
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row_q = row_r;
endmodule
`default_nettype wire

@@ verif/gf2_matrix_multiply_unit_tb.sv @@
// Testbench for gf2_matrix_multiply_unit: loads A/B/C row words, issues computes and checks
// every emitted C row against a direct GF(2) product kept in the bench.
// Depends on gf2mm_pkg and the unit's top level only.
`default_nettype none
module gf2_matrix_multiply_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gf2mm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  gf2_matrix_multiply_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the matrices and registers
  logic [63:0] mat_a [64];
  logic [63:0] mat_b [64];
  logic [63:0] mat_c [64];
  logic [6:0]  sh_rows, sh_inner, sh_cols;
  logic [3:0]  sh_chunk;
  logic        sh_acc;

  in_word_t  word_q [$];
  out_word_t c_rows_q [$];
  int errors = 0;
  int rows_seen = 0;

  function automatic int clamp_size(logic [6:0] v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  // C = A*B (or C ^= A*B); the slice/table walk gives the same sum
  task automatic multiply_rows();
    int nr, ni, nc;
    logic [63:0] mask;
    out_word_t w;
    nr = clamp_size(sh_rows);
    ni = clamp_size(sh_inner);
    nc = clamp_size(sh_cols);
    mask = (nc >= 64) ? '1 : ((64'd1 << nc) - 64'd1);
    for (int j = 0; j < nr; j++) begin
      if (!sh_acc) mat_c[j] = '0;
      for (int t = 0; t < ni; t++)
        if (mat_a[j][t]) mat_c[j] ^= mat_b[t];
      mat_c[j] &= mask;
      w.out_row_index = j[5:0];
      w.out_row_bits = mat_c[j];
      w.last = (j == nr - 1);
      c_rows_q.push_back(w);
    end
  endtask

  task automatic absorb_word(in_word_t w);
    case (cmd_t'(w.cmd))
      CMD_LOAD_A:  mat_a[w.row_index] = w.row_bits;
      CMD_LOAD_B:  mat_b[w.row_index] = w.row_bits;
      CMD_LOAD_C:  mat_c[w.row_index] = w.row_bits;
      CMD_COMPUTE: multiply_rows();
      default: ;
    endcase
  endtask

  // driver: bursts of words with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    logic acc;
    acc = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (acc) begin
        absorb_word(in_data);
        void'(word_q.pop_front());
      end
      if (!in_valid || acc) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= word_q[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off early on
  int hold_left = 0;
  int stall_mode = 0;
  bit long_done = 0;
  always @(posedge clk) begin
    if (!long_done && rows_seen == 5) begin
      long_done = 1;
      hold_left = 600;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      rows_seen++;
      if (c_rows_q.size() == 0) begin
        $display("%0t: unexpected C row word %h", $time, out_data);
        errors++;
      end else begin
        e = c_rows_q.pop_front();
        if (e.out_row_index !== out_data.out_row_index) begin
          $display("%0t: row index exp %0d got %0d", $time, e.out_row_index,
                   out_data.out_row_index);
          errors++;
        end
        if (e.out_row_bits !== out_data.out_row_bits) begin
          $display("%0t: row %0d bits exp %h got %h", $time, e.out_row_index,
                   e.out_row_bits, out_data.out_row_bits);
          errors++;
        end
        if (e.last !== out_data.last) begin
          $display("%0t: row %0d last exp %b got %b", $time, e.out_row_index,
                   e.last, out_data.last);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ROWS_A:     sh_rows = val;
      REG_INNER_SIZE: sh_inner = val;
      REG_COLS_B:     sh_cols = val;
      REG_CHUNK_BITS: sh_chunk = val[3:0];
      REG_ACCUMULATE: sh_acc = val[0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(logic [6:0] r, logic [6:0] n, logic [6:0] c, logic [6:0] k,
                           logic [6:0] a);
    cfg_write(REG_ROWS_A, r);
    cfg_write(REG_INNER_SIZE, n);
    cfg_write(REG_COLS_B, c);
    cfg_write(REG_CHUNK_BITS, k);
    cfg_write(REG_ACCUMULATE, a);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || in_valid || c_rows_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_row();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_word_t mk(cmd_t c, int idx, logic [63:0] bits);
    in_word_t w;
    w.cmd = c;
    w.row_index = idx[5:0];
    w.row_bits = bits;
    return w;
  endfunction

  task automatic random_loads(int n);
    for (int i = 0; i < n; i++)
      word_q.push_back(mk(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 63), rand_row()));
  endtask

  initial begin
    logic [6:0] r, n, c;
    sh_rows = 64; sh_inner = 64; sh_cols = 64; sh_chunk = 8; sh_acc = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // every A and B row defined once; the first multiply then defines every C row
    for (int i = 0; i < 64; i++) begin
      word_q.push_back(mk(CMD_LOAD_A, i, (i == 0) ? '1 : (i == 1) ? '0 : {$urandom, $urandom}));
      word_q.push_back(mk(CMD_LOAD_B, i, (i == 63) ? '1 : {$urandom, $urandom}));
    end
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    // words queued behind the compute wait on the stalled input during the long hold-off
    random_loads(4);
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    wait_idle();

    // directed sizes: minimum, clamped low, clamped high, k = 7 over 63 inner bits, k = 1 accumulate
    set_sizes(1, 1, 1, 1, 0);
    word_q.push_back(mk(CMD_LOAD_A, 0, '1));
    word_q.push_back(mk(CMD_LOAD_B, 0, '1));
    word_q.push_back(mk(CMD_COMPUTE, 63, '1));
    wait_idle();
    set_sizes(0, 0, 0, 0, 1);
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    wait_idle();
    set_sizes(127, 127, 127, 15, 1);
    word_q.push_back(mk(CMD_LOAD_C, 63, '1));
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    wait_idle();
    set_sizes(64, 63, 64, 7, 0);
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    wait_idle();
    set_sizes(64, 64, 64, 1, 1);
    word_q.push_back(mk(CMD_COMPUTE, 0, '0));
    wait_idle();

    // random phases, mostly small matrices
    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        r = 7'($urandom_range(0, 127));
        n = 7'($urandom_range(0, 127));
        c = 7'($urandom_range(0, 127));
      end else begin
        r = 7'($urandom_range(1, 12));
        n = 7'($urandom_range(1, 20));
        c = 7'($urandom_range(1, 64));
      end
      set_sizes(r, n, c, 7'($urandom_range(0, 15)), 7'($urandom_range(0, 1)));
      for (int s = 0; s < 2; s++) begin
        random_loads($urandom_range(1, 3));
        word_q.push_back(mk(CMD_COMPUTE, $urandom_range(0, 63), rand_row()));
      end
      wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
